### rtl/core/dop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option parser package
// Shared header length, option codes and result kind codes.
// ----------------------------------------------------------------------------
package dop_pkg;

	// fixed BOOTP/DHCP header length in bytes
	localparam logic [7:0] HEADER_BYTES = 8'd240;

	// option codes
	localparam logic [7:0] OPT_PAD        = 8'd0;
	localparam logic [7:0] OPT_HOSTNAME   = 8'd12;
	localparam logic [7:0] OPT_REQ_IP     = 8'd50;
	localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER_ID  = 8'd54;
	localparam logic [7:0] OPT_PARAM_REQ  = 8'd55;
	localparam logic [7:0] OPT_CLASS_ID   = 8'd60;
	localparam logic [7:0] OPT_CLIENT_ID  = 8'd61;
	localparam logic [7:0] OPT_END        = 8'd255;

	// kind of one result transfer
	typedef enum logic [2:0] {
		KIND_HOSTNAME  = 3'd0,
		KIND_PARAM_REQ = 3'd1,
		KIND_CLASS_ID  = 3'd2,
		KIND_CLIENT_ID = 3'd3,
		KIND_SUMMARY   = 3'd4
	} kind_t;

endpackage

### rtl/core/dop_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option parser input channel
// One payload byte per transfer, with a flag on the final byte of a packet.
// ----------------------------------------------------------------------------
interface dop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/dop_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option parser result channel
// Tagged option value bytes and the per-packet summary.
// ----------------------------------------------------------------------------
interface dop_out_if
	import dop_pkg::*;
;
	logic        valid;
	logic        ready;
	kind_t       result_kind;
	logic [7:0]  payload_byte;
	logic        ethernet_ok;
	logic [31:0] transaction_id;
	logic [15:0] flags_word;
	logic [31:0] client_addr;
	logic [31:0] relay_addr;
	logic [47:0] client_mac;
	logic [7:0]  message_type;
	logic [31:0] requested_ip;
	logic [31:0] server_id;
	logic [1:0]  present_mask;

	modport source (
		output valid, output result_kind, output payload_byte, output ethernet_ok,
		output transaction_id, output flags_word, output client_addr,
		output relay_addr, output client_mac, output message_type,
		output requested_ip, output server_id, output present_mask,
		input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte, input ethernet_ok,
		input transaction_id, input flags_word, input client_addr,
		input relay_addr, input client_mac, input message_type,
		input requested_ip, input server_id, input present_mask,
		output ready
	);
endinterface

### rtl/core/dhcp_option_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option parser
// Walks a DHCP message byte by byte, captures header fields and selected
// options, and emits tagged option bytes plus a per-packet summary.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one UDP payload byte per transfer; last_byte marks the
//          final byte of a packet.
//   out_ch carries at most one result per input byte: a value byte of
//          option 12, 55, 60 or 61 (tagged by result_kind), or, for the
//          last byte only, a summary of the header and captured options.
//   The result of a byte is valid in the cycle after its transfer.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   parse state updates in the same cycle a byte is taken.
//   The single output register decouples the sides: a new byte is taken
//   while a result waits as long as out_ch.ready is high in that cycle.
//   While the receiver stalls with a result pending, in_ch.ready is low.
//   Reset clears all parse state and the output register; the state is
//   also cleared after each last byte, ready for the next packet.
// ----------------------------------------------------------------------------
module dhcp_option_parser_top
	import dop_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	dop_in_if.sink    in_ch,
	dop_out_if.source out_ch
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_CODE   = 2'd1,
		PH_LEN    = 2'd2,
		PH_VALUE  = 2'd3
	} phase_t;

	// parse state
	phase_t      phase_q, phase_n;
	logic [7:0]  pos_q, pos_n;
	logic [7:0]  code_q, code_n;
	logic [7:0]  left_q, left_n;
	logic [2:0]  vidx_q, vidx_n;
	logic [7:0]  hwtype_q, hwtype_n;
	logic [7:0]  hwlen_q, hwlen_n;
	logic [31:0] xid_q, xid_n;
	logic [15:0] flags_q, flags_n;
	logic [31:0] ciaddr_q, ciaddr_n;
	logic [31:0] giaddr_q, giaddr_n;
	logic [47:0] mac_q, mac_n;
	logic [7:0]  msgtype_q, msgtype_n;
	logic [31:0] reqip_q, reqip_n;
	logic [31:0] srvid_q, srvid_n;
	logic [1:0]  seen_q, seen_n;

	// output register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  pbyte_q;
	logic        eth_ok_q;
	logic [31:0] o_xid_q;
	logic [15:0] o_flags_q;
	logic [31:0] o_ciaddr_q;
	logic [31:0] o_giaddr_q;
	logic [47:0] o_mac_q;
	logic [7:0]  o_msgtype_q;
	logic [31:0] o_reqip_q;
	logic [31:0] o_srvid_q;
	logic [1:0]  o_seen_q;

	logic        in_xfer;
	logic        tag_hit;
	kind_t       tag_kind;
	logic [7:0]  b;
	logic [31:0] val_word;
	logic [7:0]  left_dec;

	assign b        = in_ch.data_byte;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_xfer  = in_ch.valid && in_ch.ready;
	// value byte placed at bits 31-8i
	assign val_word = {b, 24'd0} >> {vidx_q[1:0], 3'b000};
	assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

	// tag of the current option code
	always_comb begin
		tag_hit  = 1'b1;
		tag_kind = KIND_HOSTNAME;
		unique case (code_q)
			OPT_HOSTNAME:  tag_kind = KIND_HOSTNAME;
			OPT_PARAM_REQ: tag_kind = KIND_PARAM_REQ;
			OPT_CLASS_ID:  tag_kind = KIND_CLASS_ID;
			OPT_CLIENT_ID: tag_kind = KIND_CLIENT_ID;
			default:       tag_hit  = 1'b0;
		endcase
	end

	// next parse state for the byte on the input
	logic emit_tag;
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		code_n    = code_q;
		left_n    = left_q;
		vidx_n    = vidx_q;
		hwtype_n  = hwtype_q;
		hwlen_n   = hwlen_q;
		xid_n     = xid_q;
		flags_n   = flags_q;
		ciaddr_n  = ciaddr_q;
		giaddr_n  = giaddr_q;
		mac_n     = mac_q;
		msgtype_n = msgtype_q;
		reqip_n   = reqip_q;
		srvid_n   = srvid_q;
		seen_n    = seen_q;
		emit_tag  = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q == 8'd1) begin
					hwtype_n = b;
				end else if (pos_q == 8'd2) begin
					hwlen_n = b;
				end else if (pos_q >= 8'd4 && pos_q <= 8'd7) begin
					xid_n = {xid_q[23:0], b};
				end else if (pos_q >= 8'd10 && pos_q <= 8'd11) begin
					flags_n = {flags_q[7:0], b};
				end else if (pos_q >= 8'd12 && pos_q <= 8'd15) begin
					ciaddr_n = {ciaddr_q[23:0], b};
				end else if (pos_q >= 8'd24 && pos_q <= 8'd27) begin
					giaddr_n = {giaddr_q[23:0], b};
				end else if (pos_q >= 8'd28 && pos_q <= 8'd33) begin
					mac_n = {mac_q[39:0], b};
				end
				if (pos_q >= HEADER_BYTES - 8'd1) begin
					phase_n = PH_CODE;
					pos_n   = HEADER_BYTES;
				end else begin
					pos_n = pos_q + 8'd1;
				end
			end
			PH_CODE: begin
				// pad bytes are skipped
				if (b != OPT_PAD) begin
					code_n = b;
					if (b == OPT_END) begin
						phase_n = PH_VALUE;
						left_n  = 8'd0;
					end else begin
						phase_n = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				left_n = b;
				vidx_n = 3'd0;
				if (code_q == OPT_REQ_IP) begin
					reqip_n   = 32'd0;
					seen_n[0] = 1'b1;
				end else if (code_q == OPT_SERVER_ID) begin
					srvid_n   = 32'd0;
					seen_n[1] = 1'b1;
				end else if (code_q == OPT_MSG_TYPE) begin
					msgtype_n = 8'd0;
				end
				phase_n = (b == 8'd0) ? PH_CODE : PH_VALUE;
			end
			PH_VALUE: begin
				// after the end option everything is ignored
				if (code_q != OPT_END) begin
					if (!vidx_q[2]) begin
						if (code_q == OPT_REQ_IP) begin
							reqip_n = reqip_q | val_word;
						end else if (code_q == OPT_SERVER_ID) begin
							srvid_n = srvid_q | val_word;
						end else if (code_q == OPT_MSG_TYPE && vidx_q == 3'd0) begin
							msgtype_n = b;
						end
						vidx_n = vidx_q + 3'd1;
					end
					emit_tag = tag_hit;
					left_n   = left_dec;
					if (left_dec == 8'd0) begin
						phase_n = PH_CODE;
					end
				end
			end
		endcase
	end

	// parse state registers, cleared after the last byte of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			code_q    <= '0;
			left_q    <= '0;
			vidx_q    <= '0;
			hwtype_q  <= '0;
			hwlen_q   <= '0;
			xid_q     <= '0;
			flags_q   <= '0;
			ciaddr_q  <= '0;
			giaddr_q  <= '0;
			mac_q     <= '0;
			msgtype_q <= '0;
			reqip_q   <= '0;
			srvid_q   <= '0;
			seen_q    <= '0;
		end else if (in_xfer) begin
			if (in_ch.last_byte) begin
				phase_q   <= PH_HEADER;
				pos_q     <= '0;
				code_q    <= '0;
				left_q    <= '0;
				vidx_q    <= '0;
				hwtype_q  <= '0;
				hwlen_q   <= '0;
				xid_q     <= '0;
				flags_q   <= '0;
				ciaddr_q  <= '0;
				giaddr_q  <= '0;
				mac_q     <= '0;
				msgtype_q <= '0;
				reqip_q   <= '0;
				srvid_q   <= '0;
				seen_q    <= '0;
			end else begin
				phase_q   <= phase_n;
				pos_q     <= pos_n;
				code_q    <= code_n;
				left_q    <= left_n;
				vidx_q    <= vidx_n;
				hwtype_q  <= hwtype_n;
				hwlen_q   <= hwlen_n;
				xid_q     <= xid_n;
				flags_q   <= flags_n;
				ciaddr_q  <= ciaddr_n;
				giaddr_q  <= giaddr_n;
				mac_q     <= mac_n;
				msgtype_q <= msgtype_n;
				reqip_q   <= reqip_n;
				srvid_q   <= srvid_n;
				seen_q    <= seen_n;
			end
		end
	end

	// output register: summary on the last byte, else a tagged value byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= KIND_HOSTNAME;
			pbyte_q     <= '0;
			eth_ok_q    <= 1'b0;
			o_xid_q     <= '0;
			o_flags_q   <= '0;
			o_ciaddr_q  <= '0;
			o_giaddr_q  <= '0;
			o_mac_q     <= '0;
			o_msgtype_q <= '0;
			o_reqip_q   <= '0;
			o_srvid_q   <= '0;
			o_seen_q    <= '0;
		end else if (in_xfer && in_ch.last_byte) begin
			out_valid_q <= 1'b1;
			kind_q      <= KIND_SUMMARY;
			pbyte_q     <= '0;
			eth_ok_q    <= (hwtype_n == 8'd1) && (hwlen_n == 8'd6);
			o_xid_q     <= xid_n;
			o_flags_q   <= flags_n;
			o_ciaddr_q  <= ciaddr_n;
			o_giaddr_q  <= giaddr_n;
			o_mac_q     <= mac_n;
			o_msgtype_q <= msgtype_n;
			o_reqip_q   <= reqip_n;
			o_srvid_q   <= srvid_n;
			o_seen_q    <= seen_n;
		end else if (in_xfer && emit_tag) begin
			out_valid_q <= 1'b1;
			kind_q      <= tag_kind;
			pbyte_q     <= b;
			eth_ok_q    <= 1'b0;
			o_xid_q     <= '0;
			o_flags_q   <= '0;
			o_ciaddr_q  <= '0;
			o_giaddr_q  <= '0;
			o_mac_q     <= '0;
			o_msgtype_q <= '0;
			o_reqip_q   <= '0;
			o_srvid_q   <= '0;
			o_seen_q    <= '0;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_kind    = kind_q;
	assign out_ch.payload_byte   = pbyte_q;
	assign out_ch.ethernet_ok    = eth_ok_q;
	assign out_ch.transaction_id = o_xid_q;
	assign out_ch.flags_word     = o_flags_q;
	assign out_ch.client_addr    = o_ciaddr_q;
	assign out_ch.relay_addr     = o_giaddr_q;
	assign out_ch.client_mac     = o_mac_q;
	assign out_ch.message_type   = o_msgtype_q;
	assign out_ch.requested_ip   = o_reqip_q;
	assign out_ch.server_id      = o_srvid_q;
	assign out_ch.present_mask   = o_seen_q;

endmodule
